[design/brms_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Burst read master sequencer package
// Widths, burst and ring geometry, register indexes and shared types.
// ----------------------------------------------------------------------------
package brms_pkg;

  localparam int unsigned ADDR_W      = 40;
  localparam int unsigned STEP_W      = 32;
  localparam int unsigned LEN_W       = 13;
  localparam int unsigned DATA_W      = 64;
  localparam int unsigned PEEK_W      = 12;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned CFG_W       = 40;
  localparam int unsigned CFG_IDX_W   = 2;

  localparam int unsigned BURST_BYTES = 64;
  localparam int unsigned BEAT_BYTES  = 8;
  localparam int unsigned RING_BYTES  = 4096;

  localparam int unsigned BEAT_W      = BEAT_BYTES * BYTE_W;
  localparam int unsigned RING_WORDS  = RING_BYTES / BEAT_BYTES;
  localparam int unsigned WORD_AW     = $clog2(RING_WORDS);
  localparam int unsigned LANE_W      = $clog2(BEAT_BYTES);

  localparam logic [ADDR_W-1:0] STEP_RESET = ADDR_W'(64);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BASE  = 2'd0,
    CFG_STEP  = 2'd1,
    CFG_LIMIT = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic              done;
    logic              request;
    logic [ADDR_W-1:0] address;
    logic [LEN_W-1:0]  bytes;
    logic              ready;
  } held_t;

endpackage
`default_nettype wire

[design/brms_in_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Sequencer input channel
// One clock tick per beat while ready is high: start, data beat and ring peek index.
// ----------------------------------------------------------------------------
interface brms_in_if;
  import brms_pkg::*;

  logic              valid;
  logic              ready;
  logic              start_pulse;
  logic              beat_valid;
  logic [DATA_W-1:0] beat_data;
  logic [PEEK_W-1:0] peek_index;

  modport source (output valid, start_pulse, beat_valid, beat_data, peek_index,
                  input ready);
  modport sink   (input valid, start_pulse, beat_valid, beat_data, peek_index,
                  output ready);
endinterface
`default_nettype wire

[design/brms_out_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Sequencer result channel
// Registered request, status and peeked ring byte, one beat per tick while ready is high.
// ----------------------------------------------------------------------------
interface brms_out_if;
  import brms_pkg::*;

  logic              valid;
  logic              ready;
  logic              pass_done;
  logic              request_valid;
  logic [ADDR_W-1:0] request_address;
  logic [LEN_W-1:0]  request_bytes;
  logic              accept_ready;
  logic [BYTE_W-1:0] peek_byte;

  modport source (output valid, pass_done, request_valid, request_address,
                  request_bytes, accept_ready, peek_byte, input ready);
  modport sink   (input valid, pass_done, request_valid, request_address,
                  request_bytes, accept_ready, peek_byte, output ready);
endinterface
`default_nettype wire

[design/burst_read_master_sequencer.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Burst read master sequencer
// Idle/issue/wait/read machine that walks burst requests over an offset
// range and captures read beats into a byte ring.
// ----------------------------------------------------------------------------
// One input beat is taken every clock unless the input stalls; its result
// passes through the ring read register and then the output register. The
// machine state is updated once per accepted beat; the capture ring is a
// 512 x 64-bit RAM written up to one beat per cycle, with a registered peek read.
// Ring contents are tracked by the write pointer and a wrapped flag, so bytes
// never written read as zero and no clearing pass follows reset. The block
// keeps taking beats while one result waits at the output; it stalls only
// when both the read stage and the output register are occupied.
// ----------------------------------------------------------------------------
module burst_read_master_sequencer (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            cfg_we_i,
  input  wire  [brms_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire  [brms_pkg::CFG_W-1:0]     cfg_data_i,
  brms_in_if.sink                        in_i,
  brms_out_if.source                     out_o
);
  import brms_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_ISSUE = 2'd1,
    PH_WAIT  = 2'd2,
    PH_READ  = 2'd3
  } phase_e;

  logic [ADDR_W-1:0]  base_q, limit_q;
  logic [STEP_W-1:0]  step_q;

  phase_e             phase_q, phase_d;
  logic [ADDR_W-1:0]  offset_q, offset_d;
  logic [LEN_W-1:0]   count_q, count_d;
  logic [WORD_AW-1:0] wptr_q, wptr_d;
  logic               wrapped_q, wrapped_d;
  held_t              held_q, held_d;
  logic [ADDR_W:0]    next_off;
  logic               ring_we;

  logic               accept;
  logic               valid_a_q, valid_b_q;
  logic               advance_a;
  logic [LANE_W-1:0]  lane_q;
  logic               live_q;
  logic [WORD_AW-1:0] peek_word;
  logic [BEAT_W-1:0]  ring_rdata;

  assign accept    = in_i.valid && in_i.ready;
  assign advance_a = valid_a_q && (!valid_b_q || out_o.ready);
  assign in_i.ready = !valid_a_q || advance_a;
  assign peek_word = in_i.peek_index[LANE_W +: WORD_AW];

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= '0;
      step_q  <= STEP_RESET[STEP_W-1:0];
      limit_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_BASE:  base_q  <= cfg_data_i[ADDR_W-1:0];
        CFG_STEP:  step_q  <= cfg_data_i[STEP_W-1:0];
        CFG_LIMIT: limit_q <= cfg_data_i[ADDR_W-1:0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    phase_d   = phase_q;
    offset_d  = offset_q;
    count_d   = count_q;
    wptr_d    = wptr_q;
    wrapped_d = wrapped_q;
    held_d    = held_q;
    ring_we   = 1'b0;
    next_off  = {1'b0, offset_q} + (ADDR_W + 1)'(step_q);
    case (phase_q)
      PH_IDLE: begin
        held_d   = '0;
        offset_d = '0;
        count_d  = '0;
        if (in_i.start_pulse) begin
          phase_d = PH_ISSUE;
        end
      end
      PH_ISSUE: begin
        if (next_off > {1'b0, limit_q}) begin
          held_d.done = 1'b1;
          phase_d     = PH_IDLE;
        end else begin
          held_d.address = base_q + offset_q;
          held_d.bytes   = LEN_W'(BURST_BYTES);
          held_d.request = 1'b1;
          offset_d       = next_off[ADDR_W-1:0];
          phase_d        = PH_WAIT;
        end
      end
      PH_WAIT: begin
        held_d.ready = 1'b1;
        phase_d      = PH_READ;
      end
      PH_READ: begin
        held_d.request = 1'b0;
        if (count_q >= LEN_W'(BURST_BYTES)) begin
          count_d      = '0;
          held_d.ready = 1'b0;
          phase_d      = PH_ISSUE;
        end else if (in_i.beat_valid) begin
          ring_we = 1'b1;
          count_d = count_q + LEN_W'(BEAT_BYTES);
          wptr_d  = wptr_q + WORD_AW'(1);
          if (wptr_q == WORD_AW'(RING_WORDS - 1)) begin
            wrapped_d = 1'b1;
          end
        end
      end
      default: phase_d = PH_IDLE;
    endcase
  end

  // machine state, advanced once per accepted beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      offset_q  <= '0;
      count_q   <= '0;
      wptr_q    <= '0;
      wrapped_q <= 1'b0;
      held_q    <= '0;
    end else if (accept) begin
      phase_q   <= phase_d;
      offset_q  <= offset_d;
      count_q   <= count_d;
      wptr_q    <= wptr_d;
      wrapped_q <= wrapped_d;
      held_q    <= held_d;
    end
  end

  brms_ram #(
    .WIDTH (BEAT_W),
    .DEPTH (RING_WORDS)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (accept && ring_we),
    .waddr_i (wptr_q),
    .wdata_i (in_i.beat_data[BEAT_W-1:0]),
    .re_i    (accept),
    .raddr_i (peek_word),
    .rdata_o (ring_rdata)
  );

  // read stage: held state plus ring word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
    end else if (accept) begin
      valid_a_q <= 1'b1;
    end else if (advance_a) begin
      valid_a_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      lane_q <= in_i.peek_index[LANE_W-1:0];
      live_q <= wrapped_q || (peek_word < wptr_q);
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_b_q <= 1'b0;
    end else if (advance_a) begin
      valid_b_q <= 1'b1;
    end else if (out_o.ready) begin
      valid_b_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_a) begin
      out_o.pass_done       <= held_q.done;
      out_o.request_valid   <= held_q.request;
      out_o.request_address <= held_q.address;
      out_o.request_bytes   <= held_q.bytes;
      out_o.accept_ready    <= held_q.ready;
      out_o.peek_byte       <= live_q ? ring_rdata[lane_q * BYTE_W +: BYTE_W] : '0;
    end
  end

  assign out_o.valid = valid_b_q;

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (valid_a_q && valid_b_q))
    else $error("input stalled with a free stage");

  a_request_has_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q.request |-> (held_q.bytes == LEN_W'(BURST_BYTES)))
    else $error("request without burst length");

  a_done_excludes_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(held_q.done && held_q.request))
    else $error("done and request together");

  a_ready_in_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q.ready |-> (phase_q == PH_READ))
    else $error("beat ready outside read phase");

endmodule
`default_nettype wire

[design/brms_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data (old data on
// a same-address collision).
// ----------------------------------------------------------------------------
module brms_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  wire                      clk_i,
  input  wire                      we_i,
  input  wire  [$clog2(DEPTH)-1:0] waddr_i,
  input  wire  [WIDTH-1:0]         wdata_i,
  input  wire                      re_i,
  input  wire  [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire
